// ===== rtl/bds_pkg.sv =====
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the streaming bayer demosaic block.
// ----------------------------------------------------------------------------
package bds_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_HEIGHT      = 4096;
  localparam int MIN_SIZE        = 8;
  localparam int MARGIN          = 2;
  localparam int ROWS_KEPT       = 5;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_BILINEAR = 2'd0;
  localparam logic [1:0] MODE_EDGE     = 2'd1;
  localparam logic [1:0] MODE_DIFF     = 2'd2;

  // reset values
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // input word
  typedef struct packed {
    logic [15:0] sample;
    logic        pad;
  } raw_word_t;

  // output word
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        end_of_frame;
  } rgb_word_t;

endpackage

// ===== rtl/bayer_demosaic_stream_top.sv =====
// ----------------------------------------------------------------------------
// bayer_demosaic_stream_top
// Streaming BGGR demosaic: five row banks, a 5x5 window and a three stage
// datapath give one RGB pixel per raster sample.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction
//  raw      | raw_valid raw_stall raw_word   | samples in
//  rgb      | rgb_valid rgb_stall rgb_word   | pixels out
//  cfg      | cfg_valid cfg_ready cfg_index  | register writes
//           | cfg_data                       |
//
// One word is taken every cycle unless the output stalls; a pixel follows the
// word that completes its window through bank read, green estimates, color terms.
// Pixel p leaves with sample p+2W+2; after the frame, pad words flush the rest.
// Reset (rst, synchronous) clears counters and the pipeline, row banks are not
// cleared. A stalled output holds the whole pipeline and stalls the input.
module bayer_demosaic_stream_top
  import bds_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        raw_valid,
  output logic        raw_stall,
  input  raw_word_t   raw_word,
  output logic        rgb_valid,
  input  logic        rgb_stall,
  output rgb_word_t   rgb_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = WW + 2;

  // positions of the centre, its four sides and four corners in the window
  localparam int PR [9] = '{2, 2, 2, 1, 3, 1, 1, 3, 3};
  localparam int PC [9] = '{2, 1, 3, 2, 2, 1, 3, 1, 3};

  typedef logic [SB-1:0] val_t;

  typedef struct packed {
    logic       shift;
    logic       emit;
    logic       from_mem;
    logic       border;
    logic       eof;
    logic       px;
    logic       py;
    logic [2:0] wbank;
    logic [2:0] rbank;
  } ctl_a_t;

  typedef struct packed {
    logic emit;
    logic from_mem;
    logic border;
    logic eof;
    logic px;
    logic py;
  } ctl_b_t;

  // configuration
  logic [1:0]  mode;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  // counters
  logic [CW-1:0] col_cnt;
  logic [12:0]   row_cnt;
  logic [2:0]    wbank;
  logic [CW-1:0] out_x;
  logic [12:0]   out_y;
  logic [2:0]    rbank;
  logic [LW-1:0] lag;

  // pipeline
  logic   adv;
  logic   accept;
  logic   take;
  ctl_a_t a_ctl;
  val_t   a_smp;
  val_t   a_rd [ROWS_KEPT];
  ctl_b_t b_ctl;
  val_t   b_raw;
  val_t   win [5][5];
  ctl_b_t c_ctl;
  val_t   c_raw;
  val_t   c_v [9];
  val_t   c_g [9];
  val_t   c_green;

  logic [SB-1:0] line_mem [ROWS_KEPT][MAX_WIDTH];

  // effective frame size
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [13:0]   fw14;

  always_comb begin
    fw14 = 14'(frame_width);
    if (fw14 < 14'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (fw14 > 14'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw14);
    end
    if (frame_height < 13'(MIN_SIZE)) begin
      h_eff = 13'(MIN_SIZE);
    end else if (frame_height > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // handshakes
  assign adv       = !(rgb_valid && rgb_stall);
  assign raw_stall = !adv;
  assign accept    = raw_valid && adv;
  assign cfg_ready = 1'b1;

  // input side bookkeeping
  logic          col_wrap;
  logic          done_after;
  logic [LW-1:0] lag_after;
  logic          emit;
  logic          last;
  logic          border;

  always_comb begin
    take       = (row_cnt < h_eff) && !raw_word.pad;
    col_wrap   = (WW'(col_cnt) + WW'(1)) == w_eff;
    done_after = take ? (col_wrap && (row_cnt == h_eff - 13'd1)) : (row_cnt == h_eff);
    lag_after  = lag + LW'(take);
    emit       = done_after || (lag_after >= (LW'({w_eff, 1'b0}) + LW'(3)));
    last       = (WW'(out_x) == w_eff - WW'(1)) && (out_y == h_eff - 13'd1);
    border     = (out_x < CW'(MARGIN)) || (out_y < 13'(MARGIN))
              || (WW'(out_x) >= w_eff - WW'(MARGIN))
              || (out_y >= h_eff - 13'(MARGIN));
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_DIFF;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      col_cnt      <= '0;
      row_cnt      <= '0;
      wbank        <= '0;
      out_x        <= '0;
      out_y        <= '0;
      rbank        <= '0;
      lag          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   mode <= cfg_data[1:0];
        REG_WIDTH:  frame_width <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default:    ;
      endcase
      if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
        col_cnt <= '0;
        row_cnt <= '0;
        wbank   <= '0;
        out_x   <= '0;
        out_y   <= '0;
        rbank   <= '0;
        lag     <= '0;
      end
    end else if (accept) begin
      if (take) begin
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 13'd1;
          wbank   <= (wbank == 3'(ROWS_KEPT - 1)) ? 3'd0 : wbank + 3'd1;
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      lag <= emit ? lag_after - LW'(1) : lag_after;
      if (emit) begin
        if (WW'(out_x) == w_eff - WW'(1)) begin
          out_x <= '0;
          out_y <= out_y + 13'd1;
          rbank <= (rbank == 3'(ROWS_KEPT - 1)) ? 3'd0 : rbank + 3'd1;
        end else begin
          out_x <= out_x + CW'(1);
        end
        if (last) begin
          col_cnt <= '0;
          row_cnt <= '0;
          wbank   <= '0;
          out_x   <= '0;
          out_y   <= '0;
          rbank   <= '0;
          lag     <= '0;
        end
      end
    end
  end

  // row banks: write the new sample, read one column of every bank
  logic [CW-1:0] rd_addr;
  assign rd_addr = take ? col_cnt : out_x;

  always_ff @(posedge clk) begin
    for (int b = 0; b < ROWS_KEPT; b++) begin
      if (accept && take && (wbank == 3'(b))) begin
        line_mem[b][col_cnt] <= raw_word.sample[SB-1:0];
      end
      if (adv) begin
        a_rd[b] <= line_mem[b][rd_addr];
      end
    end
  end

  // stage a control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (adv) begin
      a_ctl.shift    <= accept && take;
      a_ctl.emit     <= accept && emit;
      a_ctl.from_mem <= !take;
      a_ctl.border   <= border;
      a_ctl.eof      <= last;
      a_ctl.px       <= out_x[0];
      a_ctl.py       <= out_y[0];
      a_ctl.wbank    <= wbank;
      a_ctl.rbank    <= rbank;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_smp <= raw_word.sample[SB-1:0];
    end
  end

  // column into the window, oldest row on top
  val_t col [5];
  logic [3:0] bsel;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bsel = 4'(a_ctl.wbank) + 4'(j + 1);
      if (bsel >= 4'(ROWS_KEPT)) begin
        bsel = bsel - 4'(ROWS_KEPT);
      end
      col[j] = a_rd[bsel[2:0]];
    end
    bsel   = '0;
    col[4] = a_smp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_ctl.shift) begin
        for (int r = 0; r < 5; r++) begin
          for (int c = 0; c < 4; c++) begin
            win[r][c] <= win[r][c + 1];
          end
          win[r][4] <= col[r];
        end
      end
      b_raw <= a_rd[a_ctl.rbank];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (adv) begin
      b_ctl.emit     <= a_ctl.emit;
      b_ctl.from_mem <= a_ctl.from_mem;
      b_ctl.border   <= a_ctl.border;
      b_ctl.eof      <= a_ctl.eof;
      b_ctl.px       <= a_ctl.px;
      b_ctl.py       <= a_ctl.py;
    end
  end

  // edge-directed green from the four side neighbors
  function automatic val_t edge_green(input val_t l, input val_t r, input val_t u,
                                      input val_t d);
    val_t      dv;
    val_t      dh;
    logic [SB:0] sv;
    logic [SB:0] sh;
    dv = (d >= u) ? d - u : u - d;
    dh = (r >= l) ? r - l : l - r;
    sv = (SB + 1)'(u) + (SB + 1)'(d);
    sh = (SB + 1)'(l) + (SB + 1)'(r);
    return (dv <= dh) ? sv[SB:1] : sh[SB:1];
  endfunction

  // stage b: green estimates at the centre and its eight neighbors
  val_t        g_est [9];
  val_t        v_pos [9];
  logic [SB+1:0] bil_sum;
  val_t        green_b;
  val_t        raw_b;
  logic        c_is_green;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      v_pos[k] = win[PR[k]][PC[k]];
      if (b_ctl.px ^ b_ctl.py ^ PR[k][0] ^ PC[k][0]) begin
        g_est[k] = v_pos[k];
      end else begin
        g_est[k] = edge_green(win[PR[k]][PC[k] - 1], win[PR[k]][PC[k] + 1],
                              win[PR[k] - 1][PC[k]], win[PR[k] + 1][PC[k]]);
      end
    end
    bil_sum = (SB + 2)'(win[2][1]) + (SB + 2)'(win[2][3])
            + (SB + 2)'(win[1][2]) + (SB + 2)'(win[3][2]);
    c_is_green = b_ctl.px ^ b_ctl.py;
    if (c_is_green) begin
      green_b = win[2][2];
    end else if (mode == MODE_BILINEAR) begin
      green_b = bil_sum[SB+1:2];
    end else begin
      green_b = g_est[0];
    end
    raw_b = b_ctl.from_mem ? b_raw : win[2][2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_v     <= v_pos;
      c_g     <= g_est;
      c_green <= green_b;
      c_raw   <= raw_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else if (adv) begin
      c_ctl <= b_ctl;
    end
  end

  // stage c: red and blue from neighbor terms
  function automatic val_t chroma(input logic px, input logic py, input logic cc,
                                  input logic diff, input val_t v [9],
                                  input val_t g [9]);
    logic signed [SB:0]   t [9];
    logic signed [SB+2:0] s;
    logic signed [SB+3:0] e;
    for (int k = 0; k < 9; k++) begin
      t[k] = diff ? $signed({1'b0, v[k]}) - $signed({1'b0, g[k]})
                  : $signed({1'b0, v[k]});
    end
    if (px == cc && py == cc) begin
      return v[0];
    end
    if (px != cc && py == cc) begin
      s = (SB + 3)'(t[1]) + (SB + 3)'(t[2]);
      s = s >>> 1;
    end else if (px == cc) begin
      s = (SB + 3)'(t[3]) + (SB + 3)'(t[4]);
      s = s >>> 1;
    end else begin
      s = (SB + 3)'(t[5]) + (SB + 3)'(t[6]) + (SB + 3)'(t[7]) + (SB + 3)'(t[8]);
      s = s >>> 2;
    end
    e = (SB + 4)'(s);
    if (diff) begin
      e = e + $signed({4'b0, g[0]});
    end
    if (e < 0) begin
      return '0;
    end
    if (e > $signed({4'b0, {SB{1'b1}}})) begin
      return {SB{1'b1}};
    end
    return e[SB-1:0];
  endfunction

  val_t red_c;
  val_t blue_c;
  logic diff_mode;

  always_comb begin
    diff_mode = mode[1];
    red_c     = chroma(c_ctl.px, c_ctl.py, 1'b1, diff_mode, c_v, c_g);
    blue_c    = chroma(c_ctl.px, c_ctl.py, 1'b0, diff_mode, c_v, c_g);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (adv) begin
      rgb_valid <= c_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_ctl.emit) begin
      if (c_ctl.border) begin
        rgb_word.red   <= 16'(c_raw);
        rgb_word.green <= 16'(c_raw);
        rgb_word.blue  <= 16'(c_raw);
      end else begin
        rgb_word.red   <= 16'(red_c);
        rgb_word.green <= 16'(c_green);
        rgb_word.blue  <= 16'(blue_c);
      end
      rgb_word.end_of_frame <= c_ctl.eof;
    end
  end

endmodule
